// File: rtl/core/ssc_pkg.sv
package ssc_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLANKING_DELAY = 1'b0,
        CFG_STARTUP_STEPS  = 1'b1
    } cfg_index_t;

    localparam logic [7:0] OPEN_LOOP_DELAY = 8'd26;
    localparam logic [7:0] STARTUP_RESET   = 8'd6;
    localparam logic [2:0] TOP_STEP        = 3'd6;

    localparam logic [2:0] PH_NONE = 3'b000;
    localparam logic [2:0] PH_U    = 3'b001;
    localparam logic [2:0] PH_V    = 3'b010;
    localparam logic [2:0] PH_W    = 3'b100;

    typedef struct packed {
        logic u;
        logic v;
        logic w;
    } phase_t;

    typedef struct packed {
        logic [2:0] high_side_on;
        logic [2:0] low_side_on;
        logic       pattern_applied;
        logic [2:0] current_step;
        logic       closed_loop;
        logic [7:0] step_changes;
    } result_t;

    function automatic logic [2:0] high_pattern(input logic [2:0] s);
        logic [2:0] p;
        case (s)
            3'd1:    p = PH_V;
            3'd2:    p = PH_U;
            3'd3:    p = PH_U;
            3'd4:    p = PH_W;
            3'd5:    p = PH_W;
            3'd6:    p = PH_V;
            default: p = PH_NONE;
        endcase
        return p;
    endfunction

    function automatic logic [2:0] low_pattern(input logic [2:0] s);
        logic [2:0] p;
        case (s)
            3'd1:    p = PH_W;
            3'd2:    p = PH_W;
            3'd3:    p = PH_V;
            3'd4:    p = PH_V;
            3'd5:    p = PH_U;
            3'd6:    p = PH_U;
            default: p = PH_NONE;
        endcase
        return p;
    endfunction

    // back-EMF zero crossing expected in each step
    function automatic logic edge_seen(input logic [2:0] s, input phase_t ph);
        logic e;
        case (s)
            3'd1:    e = ph.u;
            3'd2:    e = ~ph.v;
            3'd3:    e = ph.w;
            3'd4:    e = ~ph.u;
            3'd5:    e = ph.v;
            3'd6:    e = ~ph.w;
            default: e = 1'b0;
        endcase
        return e;
    endfunction

endpackage

// File: rtl/core/ssc_phase_if.sv
interface ssc_phase_if;
    logic valid;
    logic ready;
    logic phase_u_high;
    logic phase_v_high;
    logic phase_w_high;

    modport source (output valid, output phase_u_high, output phase_v_high,
                    output phase_w_high, input ready);
    modport sink (input valid, input phase_u_high, input phase_v_high,
                  input phase_w_high, output ready);
endinterface

// File: rtl/core/ssc_drive_if.sv
interface ssc_drive_if;
    logic       valid;
    logic       ready;
    logic [2:0] high_side_on;
    logic [2:0] low_side_on;
    logic       pattern_applied;
    logic [2:0] current_step;
    logic       closed_loop;
    logic [7:0] step_changes;

    modport source (output valid, output high_side_on, output low_side_on,
                    output pattern_applied, output current_step,
                    output closed_loop, output step_changes, input ready);
    modport sink (input valid, input high_side_on, input low_side_on,
                  input pattern_applied, input current_step,
                  input closed_loop, input step_changes, output ready);
endinterface

// File: rtl/core/ssc_in_stage.sv
module ssc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    ssc_phase_if.sink      phases,
    input  logic           take,
    output logic           item_valid,
    output ssc_pkg::phase_t item
);

    logic            valid_reg;
    logic            valid_next;
    ssc_pkg::phase_t item_reg;
    logic            load;

    assign phases.ready = ~valid_reg | take;
    assign load         = phases.valid & phases.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.u <= phases.phase_u_high;
            item_reg.v <= phases.phase_v_high;
            item_reg.w <= phases.phase_w_high;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/ssc_core.sv
module ssc_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  ssc_pkg::phase_t                    item,
    input  logic                               cfg_we,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ssc_pkg::result_t                   result
);

    logic [7:0] blanking_reg, blanking_next;
    logic [7:0] startup_steps_reg, startup_steps_next;
    logic [2:0] step_reg, step_next;
    logic [2:0] last_step_reg, last_step_next;
    logic       drive_done_reg, drive_done_next;
    logic       sensing_reg, sensing_next;
    logic [7:0] startup_count_reg, startup_count_next;
    logic [7:0] hold_reg, hold_next;
    logic [7:0] change_reg, change_next;
    logic [2:0] high_reg, high_next;
    logic [2:0] low_reg, low_next;
    logic       applied;

    // next state for the item in the input register
    always_comb
    begin
        blanking_next      = blanking_reg;
        step_next          = step_reg;
        last_step_next     = last_step_reg;
        drive_done_next    = drive_done_reg;
        sensing_next       = sensing_reg;
        startup_count_next = startup_count_reg;
        hold_next          = hold_reg;
        change_next        = change_reg;
        high_next          = high_reg;
        low_next           = low_reg;
        applied            = 1'b0;

        if (hold_reg != 8'd0)
        begin
            hold_next = hold_reg - 8'd1;
        end
        else
        begin
            if (!sensing_reg)
            begin
                if (startup_count_reg == startup_steps_reg)
                begin
                    sensing_next = 1'b1;
                end
                startup_count_next = startup_count_reg + 8'd1;
                // open loop walks down 6..1 and wraps
                if (step_reg <= 3'd1)
                begin
                    step_next = ssc_pkg::TOP_STEP;
                end
                else
                begin
                    step_next = step_reg - 3'd1;
                end
                blanking_next = ssc_pkg::OPEN_LOOP_DELAY;
            end
            if (last_step_reg != step_next)
            begin
                last_step_next  = step_next;
                drive_done_next = 1'b0;
                change_next     = change_reg + 8'd1;
            end
            if (step_next >= 3'd1 && step_next <= ssc_pkg::TOP_STEP)
            begin
                if (sensing_next && ssc_pkg::edge_seen(step_next, item))
                begin
                    hold_next = blanking_next;
                    if (step_next == 3'd1)
                    begin
                        step_next = ssc_pkg::TOP_STEP;
                    end
                    else
                    begin
                        step_next = step_next - 3'd1;
                    end
                end
                else if (!drive_done_next)
                begin
                    high_next       = ssc_pkg::high_pattern(step_next);
                    low_next        = ssc_pkg::low_pattern(step_next);
                    drive_done_next = 1'b1;
                    applied         = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        startup_steps_next = startup_steps_reg;
        if (cfg_we && cfg_index == ssc_pkg::CFG_STARTUP_STEPS)
        begin
            startup_steps_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blanking_reg      <= ssc_pkg::OPEN_LOOP_DELAY;
            startup_steps_reg <= ssc_pkg::STARTUP_RESET;
            step_reg          <= 3'd0;
            last_step_reg     <= 3'd0;
            drive_done_reg    <= 1'b0;
            sensing_reg       <= 1'b0;
            startup_count_reg <= 8'd0;
            hold_reg          <= 8'd0;
            change_reg        <= 8'd0;
            high_reg          <= 3'd0;
            low_reg           <= 3'd0;
        end
        else
        begin
            startup_steps_reg <= startup_steps_next;
            if (cfg_we && cfg_index == ssc_pkg::CFG_BLANKING_DELAY)
            begin
                blanking_reg <= cfg_data;
            end
            else if (advance)
            begin
                blanking_reg <= blanking_next;
            end
            if (advance)
            begin
                step_reg          <= step_next;
                last_step_reg     <= last_step_next;
                drive_done_reg    <= drive_done_next;
                sensing_reg       <= sensing_next;
                startup_count_reg <= startup_count_next;
                hold_reg          <= hold_next;
                change_reg        <= change_next;
                high_reg          <= high_next;
                low_reg           <= low_next;
            end
        end
    end

    assign result.high_side_on    = high_next;
    assign result.low_side_on     = low_next;
    assign result.pattern_applied = applied;
    assign result.current_step    = step_next;
    assign result.closed_loop     = sensing_next;
    assign result.step_changes    = change_next;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= ssc_pkg::TOP_STEP)
        else $error("step out of range");

    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sensing_reg |=> sensing_reg)
        else $error("closed loop dropped");

    a_blank_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && hold_reg != 8'd0) |=>
            (hold_reg == $past(hold_reg) - 8'd1 && step_reg == $past(step_reg)))
        else $error("blanking tick changed state");

    a_step_started: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> step_reg != 3'd0)
        else $error("no step after a tick");

    a_applied_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && applied) |=> drive_done_reg)
        else $error("pattern driven without drive_done");

endmodule

// File: rtl/core/ssc_out_stage.sv
module ssc_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  ssc_pkg::result_t result,
    ssc_drive_if.source      drive,
    output logic             take
);

    logic             valid_reg;
    logic             valid_next;
    ssc_pkg::result_t result_reg;

    assign take = item_valid & (~valid_reg | drive.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (drive.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result;
        end
    end

    assign drive.valid           = valid_reg;
    assign drive.high_side_on    = result_reg.high_side_on;
    assign drive.low_side_on     = result_reg.low_side_on;
    assign drive.pattern_applied = result_reg.pattern_applied;
    assign drive.current_step    = result_reg.current_step;
    assign drive.closed_loop     = result_reg.closed_loop;
    assign drive.step_changes    = result_reg.step_changes;

endmodule

// File: rtl/core/sensorless_six_step_commutator.sv
// Six-step sensorless commutator. Takes one comparator tick per clock and
// returns one drive result per tick: input register, step/blanking state
// update, result register. Throughput is one item per cycle for as long as
// the drive side is ready. The user must write configuration (blanking_delay
// index 0, startup_steps index 1) while no item is in flight; the block
// itself does not enforce this.
module sensorless_six_step_commutator (
    input  logic                               clk,
    input  logic                               rst_n,
    ssc_phase_if.sink                          phases,
    ssc_drive_if.source                        drive,
    input  logic                               cfg_we,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic             advance;
    logic             item_valid;
    ssc_pkg::phase_t  item;
    ssc_pkg::result_t result;

    ssc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .phases     (phases),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ssc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    ssc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .drive      (drive),
        .take       (advance)
    );

endmodule

// File: test/tb_sensorless_six_step_commutator.sv
`timescale 1ns / 1ps

module tb_sensorless_six_step_commutator;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_CADENCE,
        RX_TRICKLE
    } rx_pattern_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    ssc_pkg::cfg_index_t             cfg_index;
    logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data;

    ssc_phase_if phases_bus ();
    ssc_drive_if drive_bus ();

    sensorless_six_step_commutator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .phases    (phases_bus),
        .drive     (drive_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // commutator model state
    logic [7:0] blank_setting;
    logic [7:0] startup_setting;
    logic [2:0] m_step;
    logic [2:0] m_last_step;
    logic       m_driven;
    logic       m_sensing;
    logic [7:0] m_startup_cnt;
    logic [7:0] m_hold;
    logic [7:0] m_changes;
    logic [2:0] m_high;
    logic [2:0] m_low;

    ssc_pkg::result_t pending_drives[$];
    int               mismatches;
    int               ticks_sent;
    int               drives_checked;
    int               commutations;
    int               holdoff_req;
    int               holdoff_left;
    int               mode_left;
    int               cadence;
    rx_pattern_t      rx_mode;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic ssc_pkg::result_t commutate_tick(ssc_pkg::phase_t ph);
        ssc_pkg::result_t r;
        logic             applied;
        logic             crossing;
        applied = 1'b0;
        if (m_hold != 8'd0)
        begin
            m_hold = m_hold - 8'd1;
        end
        else
        begin
            if (!m_sensing)
            begin
                if (m_startup_cnt == startup_setting)
                    m_sensing = 1'b1;
                m_startup_cnt = m_startup_cnt + 8'd1;
                if (m_step > 3'd0)
                    m_step = m_step - 3'd1;
                if (m_step == 3'd0)
                    m_step = ssc_pkg::TOP_STEP;
                // open loop keeps forcing the default blanking
                blank_setting = ssc_pkg::OPEN_LOOP_DELAY;
            end
            if (m_last_step != m_step)
            begin
                m_last_step = m_step;
                m_driven = 1'b0;
                m_changes = m_changes + 8'd1;
            end
            if (m_step >= 3'd1 && m_step <= ssc_pkg::TOP_STEP)
            begin
                case (m_step)
                    3'd1:    crossing = ph.u;
                    3'd2:    crossing = !ph.v;
                    3'd3:    crossing = ph.w;
                    3'd4:    crossing = !ph.u;
                    3'd5:    crossing = ph.v;
                    default: crossing = !ph.w;
                endcase
                if (m_sensing && crossing)
                begin
                    m_step = (m_step == 3'd1) ? ssc_pkg::TOP_STEP : m_step - 3'd1;
                    m_hold = blank_setting;
                    commutations++;
                end
                else if (!m_driven)
                begin
                    case (m_step)
                        3'd1:    begin m_high = ssc_pkg::PH_V; m_low = ssc_pkg::PH_W; end
                        3'd2:    begin m_high = ssc_pkg::PH_U; m_low = ssc_pkg::PH_W; end
                        3'd3:    begin m_high = ssc_pkg::PH_U; m_low = ssc_pkg::PH_V; end
                        3'd4:    begin m_high = ssc_pkg::PH_W; m_low = ssc_pkg::PH_V; end
                        3'd5:    begin m_high = ssc_pkg::PH_W; m_low = ssc_pkg::PH_U; end
                        default: begin m_high = ssc_pkg::PH_V; m_low = ssc_pkg::PH_U; end
                    endcase
                    m_driven = 1'b1;
                    applied = 1'b1;
                end
            end
        end
        r.high_side_on    = m_high;
        r.low_side_on     = m_low;
        r.pattern_applied = applied;
        r.current_step    = m_step;
        r.closed_loop     = m_sensing;
        r.step_changes    = m_changes;
        return r;
    endfunction

    // force the comparator the current step watches so the crossing is (not) seen
    function automatic ssc_pkg::phase_t phases_for(logic want_edge, ssc_pkg::phase_t base);
        ssc_pkg::phase_t ph;
        ph = base;
        case (m_step)
            3'd1:    ph.u = want_edge;
            3'd2:    ph.v = !want_edge;
            3'd3:    ph.w = want_edge;
            3'd4:    ph.u = !want_edge;
            3'd5:    ph.v = want_edge;
            3'd6:    ph.w = !want_edge;
            default: ph = base;
        endcase
        return ph;
    endfunction

    function automatic ssc_pkg::phase_t pick_phases(int edge_pct);
        ssc_pkg::phase_t base;
        base = ssc_pkg::phase_t'($urandom_range(7));
        if ($urandom_range(99) < 10)
            return base;
        return phases_for($urandom_range(99) < edge_pct, base);
    endfunction

    task automatic send_tick(ssc_pkg::phase_t ph);
        @(negedge clk);
        phases_bus.valid        = 1'b1;
        phases_bus.phase_u_high = ph.u;
        phases_bus.phase_v_high = ph.v;
        phases_bus.phase_w_high = ph.w;
        do
            @(posedge clk);
        while (!phases_bus.ready);
        pending_drives.push_back(commutate_tick(ph));
        ticks_sent++;
    endtask

    task automatic idle_input(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            phases_bus.valid = 1'b0;
        end
    endtask

    task automatic drain_drives();
        idle_input(1);
        while (pending_drives.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(ssc_pkg::cfg_index_t idx, logic [7:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            ssc_pkg::CFG_BLANKING_DELAY: blank_setting = val;
            ssc_pkg::CFG_STARTUP_STEPS:  startup_setting = val;
            default:                     blank_setting = blank_setting;
        endcase
    endtask

    // bursts of ticks; gaps between bursts unless gaps is clear
    task automatic stream(int count, int edge_pct, bit gaps);
        int burst;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    send_tick(pick_phases(edge_pct));
                    sent++;
                end
            end
            if (gaps && $urandom_range(3) != 0)
                idle_input($urandom_range(1, 6));
        end
        idle_input(1);
    endtask

    // longest start-up: 256 open-loop ticks, start-up counter wraps on the switch tick
    task automatic test_open_loop_startup();
        write_reg(ssc_pkg::CFG_STARTUP_STEPS, 8'd255);
        write_reg(ssc_pkg::CFG_BLANKING_DELAY, 8'd200);
        stream(276, 50, 1'b1);
        drain_drives();
    endtask

    task automatic test_directed_steps();
        ssc_pkg::phase_t fill;
        write_reg(ssc_pkg::CFG_BLANKING_DELAY, 8'd1);
        while (m_hold != 8'd0)
            send_tick(ssc_pkg::phase_t'($urandom_range(7)));
        // each step: pattern drive, crossing, blanking tick
        for (int i = 0; i < 6; i++)
        begin
            fill = (i % 2) ? 3'b111 : 3'b000;
            send_tick(phases_for(1'b0, fill));
            send_tick(phases_for(1'b1, fill));
            send_tick(phases_for(1'b0, ~fill));
        end
        drain_drives();
        // zero blanking: back-to-back crossings never drive a pattern
        write_reg(ssc_pkg::CFG_BLANKING_DELAY, 8'd0);
        send_tick(phases_for(1'b1, 3'b000));
        send_tick(phases_for(1'b1, 3'b111));
        send_tick(phases_for(1'b1, 3'b010));
        send_tick(phases_for(1'b0, 3'b101));
        drain_drives();
    endtask

    task automatic test_blanking_extremes();
        write_reg(ssc_pkg::CFG_BLANKING_DELAY, 8'd0);
        stream(150, 60, 1'b1);
        drain_drives();
        write_reg(ssc_pkg::CFG_BLANKING_DELAY, 8'd255);
        stream(150, 70, 1'b1);
        drain_drives();
    endtask

    task automatic test_backpressure();
        write_reg(ssc_pkg::CFG_BLANKING_DELAY, 8'd2);
        write_reg(ssc_pkg::CFG_STARTUP_STEPS, 8'd0);
        @(posedge clk);
        holdoff_req = 300;
        stream(100, 50, 1'b0);
        drain_drives();
    endtask

    task automatic test_sender_pause();
        stream(50, 50, 1'b1);
        drain_drives();
        idle_input(20);
        stream(50, 50, 1'b1);
        drain_drives();
    endtask

    task automatic test_random_settings();
        for (int k = 0; k < 5; k++)
        begin
            write_reg(ssc_pkg::CFG_BLANKING_DELAY, 8'($urandom_range(0, 12)));
            if (k == 2)
                write_reg(ssc_pkg::CFG_STARTUP_STEPS, 8'($urandom_range(0, 255)));
            stream(100, $urandom_range(30, 80), k != 1);
            drain_drives();
        end
    endtask

    // drive side: stall patterns, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            drive_bus.ready = 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            drive_bus.ready = 1'b0;
            holdoff_left--;
        end
        else if (holdoff_req != 0)
        begin
            drive_bus.ready = 1'b0;
            holdoff_left = holdoff_req - 1;
            holdoff_req = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_pattern_t'($urandom_range(3));
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            cadence++;
            case (rx_mode)
                RX_STREAM:  drive_bus.ready = 1'b1;
                RX_COIN:    drive_bus.ready = 1'($urandom_range(1));
                RX_CADENCE: drive_bus.ready = (cadence % 3) != 0;
                default:    drive_bus.ready = ($urandom_range(3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        ssc_pkg::result_t want;
        if (rst_n && drive_bus.valid && drive_bus.ready)
        begin
            if (pending_drives.size() == 0)
            begin
                $error("drive item with nothing predicted");
                mismatches++;
            end
            else
            begin
                want = pending_drives.pop_front();
                drives_checked++;
                if (drive_bus.high_side_on !== want.high_side_on)
                begin
                    $error("high_side_on: expected %0d, got %0d",
                           want.high_side_on, drive_bus.high_side_on);
                    mismatches++;
                end
                if (drive_bus.low_side_on !== want.low_side_on)
                begin
                    $error("low_side_on: expected %0d, got %0d",
                           want.low_side_on, drive_bus.low_side_on);
                    mismatches++;
                end
                if (drive_bus.pattern_applied !== want.pattern_applied)
                begin
                    $error("pattern_applied: expected %0d, got %0d",
                           want.pattern_applied, drive_bus.pattern_applied);
                    mismatches++;
                end
                if (drive_bus.current_step !== want.current_step)
                begin
                    $error("current_step: expected %0d, got %0d",
                           want.current_step, drive_bus.current_step);
                    mismatches++;
                end
                if (drive_bus.closed_loop !== want.closed_loop)
                begin
                    $error("closed_loop: expected %0d, got %0d",
                           want.closed_loop, drive_bus.closed_loop);
                    mismatches++;
                end
                if (drive_bus.step_changes !== want.step_changes)
                begin
                    $error("step_changes: expected %0d, got %0d",
                           want.step_changes, drive_bus.step_changes);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = ssc_pkg::CFG_BLANKING_DELAY;
        cfg_data                = '0;
        phases_bus.valid        = 1'b0;
        phases_bus.phase_u_high = 1'b0;
        phases_bus.phase_v_high = 1'b0;
        phases_bus.phase_w_high = 1'b0;
        drive_bus.ready         = 1'b0;
        mismatches              = 0;
        ticks_sent              = 0;
        drives_checked          = 0;
        commutations            = 0;
        holdoff_req             = 0;
        holdoff_left            = 0;
        mode_left               = 0;
        cadence                 = 0;
        rx_mode                 = RX_STREAM;
        blank_setting           = ssc_pkg::OPEN_LOOP_DELAY;
        startup_setting         = ssc_pkg::STARTUP_RESET;
        m_step                  = 3'd0;
        m_last_step             = 3'd0;
        m_driven                = 1'b0;
        m_sensing               = 1'b0;
        m_startup_cnt           = 8'd0;
        m_hold                  = 8'd0;
        m_changes               = 8'd0;
        m_high                  = ssc_pkg::PH_NONE;
        m_low                   = ssc_pkg::PH_NONE;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_open_loop_startup();
        test_directed_steps();
        test_blanking_extremes();
        test_backpressure();
        test_sender_pause();
        test_random_settings();

        drain_drives();
        repeat (8) @(posedge clk);
        $display("Ticks sent: %0d, drive items checked: %0d, closed-loop commutations: %0d",
                 ticks_sent, drives_checked, commutations);
        $display("Covered 256-tick start-up, blanking 0..255, long output stall, input pause");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ssc_pkg.sv
rtl/core/ssc_phase_if.sv
rtl/core/ssc_drive_if.sv
rtl/core/ssc_in_stage.sv
rtl/core/ssc_core.sv
rtl/core/ssc_out_stage.sv
rtl/core/sensorless_six_step_commutator.sv
test/tb_sensorless_six_step_commutator.sv
